### hdl/cqsw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cqsw_pkg
// Shared types and constants for the command queue with sync waits.
// ----------------------------------------------------------------------------
package cqsw_pkg;

    typedef logic [2:0] mode_t;

    localparam mode_t MODE_WINDOW    = 3'd0;
    localparam mode_t MODE_LAUNCH    = 3'd1;
    localparam mode_t MODE_INDICATOR = 3'd2;
    localparam mode_t MODE_WR_DONE   = 3'd3;
    localparam mode_t MODE_RETRY     = 3'd4;
    localparam mode_t MODE_TICK      = 3'd5;

    localparam logic [63:0] CTRL_PUSH      = 64'd0;
    localparam logic [63:0] CTRL_POP       = 64'd1;
    localparam logic [63:0] CTRL_SYNC_DONE = 64'd2;

    localparam logic [3:0] DTYPE_SYNC     = 4'h1;
    localparam logic [7:0] OP_SYNC_WAIT   = 8'h00;
    localparam logic [7:0] OP_IND_SET     = 8'h01;
    localparam logic [30:0] ADDR_BASE     = 31'h7000_0000;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 112;

    // mask of the low n bytes of a 64-bit word
    function automatic logic [63:0] bytes_mask(input logic [4:0] n);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (5'(b) < n) begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

### hdl/command_queue_with_sync_waits.sv
`default_nettype none
// ----------------------------------------------------------------------------
// command_queue_with_sync_waits
// Command FIFO fed through per-port register windows, with sync-wait
// commands released by indicator bits and a single downstream write port.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------
//  s_       | in  | s_tvalid/s_tready  | s_tuser mode, s_tdata access fields
//  m_       | out | m_tvalid/m_tready  | m_tdata one result per item
//  cfg_     | in  | cfg_we             | cfg_wdata downstream_present
//
// An item that does not touch the queue head is accepted in ST_IDLE and
// gives its result in ST_FINISH. Otherwise each head command examined takes
// a RAM read (ST_HEAD_RD) and an evaluate step (ST_HEAD_EV), and one more
// head check in ST_HEAD_RD ends the walk when it stops on a busy, blocked or
// empty queue instead of on an examined command.
// Reset is synchronous, active low; the command RAM is not cleared, only
// written entries are ever read. A result held in the output register stalls
// the next item only in ST_FINISH; s_tready is high only while idle.
// ----------------------------------------------------------------------------
module command_queue_with_sync_waits
    import cqsw_pkg::*;
#(
    parameter int NUM_PORTS      = 4,
    parameter int CMD_BYTES      = 8,
    parameter int QUEUE_DEPTH    = 16,
    parameter int NUM_INDICATORS = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // port[1:0] offset[9:2] size[14:10] is_write[15] data[79:16] mem_accept[80]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // mode[2:0]
    input  wire logic [2:0]           s_tuser,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // accepted[0] deferred[1] released_mask[5:2] dispatch_valid[6]
    // dispatch_addr[37:7] dispatch_data[101:38] can_push[102]
    // occupancy[107:103] pop_empty_error[108]
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_wdata
);
    localparam int AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int PW  = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int IW  = (NUM_INDICATORS > 1) ? $clog2(NUM_INDICATORS) : 1;
    localparam int WIN = 2 * CMD_BYTES;
    localparam logic [63:0] CMD_MASK = 64'((65'd1 << (8 * CMD_BYTES)) - 65'd1);

    typedef enum logic [1:0] {ST_IDLE, ST_HEAD_RD, ST_HEAD_EV, ST_FINISH} state_t;

    // input field split
    logic [1:0]  in_port;
    logic [7:0]  in_off;
    logic [4:0]  in_size;
    logic        in_wr;
    logic [63:0] in_data;
    logic        in_macc;
    mode_t       in_mode;

    assign in_port = s_tdata[1:0];
    assign in_off  = s_tdata[9:2];
    assign in_size = s_tdata[14:10];
    assign in_wr   = s_tdata[15];
    assign in_data = s_tdata[79:16];
    assign in_macc = s_tdata[80];
    assign in_mode = s_tuser;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [63:0]             stage_reg [NUM_PORTS];
    logic [63:0]             stage_next [NUM_PORTS];
    logic [NUM_INDICATORS-1:0] ind_reg, ind_next;
    logic [NUM_PORTS-1:0]    pend_reg, pend_next;
    logic                    gate_reg, gate_next;
    logic                    wif_reg, wif_next;
    logic                    ar_reg, ar_next;
    logic [63:0]             held_reg, held_next;
    logic                    present_reg, present_next;
    logic                    macc_reg, macc_next;
    logic                    acc_reg, acc_next;
    logic                    defer_reg, defer_next;
    logic                    perr_reg, perr_next;
    logic                    offv_reg, offv_next;
    logic [63:0]             offd_reg, offd_next;
    logic                    m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]    m_data_reg, m_data_next;

    // command RAM
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [63:0]             ram_wdata;
    logic [63:0]             ram_rdata;

    cqsw_ram #(.WIDTH(64), .DEPTH(QUEUE_DEPTH)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        logic            port_ok;
        logic [PW-1:0]   pidx;
        logic [8:0]      end_off;
        logic [63:0]     shifted;
        logic [63:0]     ctrl;
        logic            enq_req;
        logic [63:0]     enq_cmd;
        logic            enq_ok;
        logic            run_head;
        logic [AW:0]     tail_sum;
        logic [7:0]      ind_idx;
        logic [3:0]      rel;
        logic            drained;
        logic [30:0]     addr;

        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        stage_next   = stage_reg;
        ind_next     = ind_reg;
        pend_next    = pend_reg;
        gate_next    = gate_reg;
        wif_next     = wif_reg;
        ar_next      = ar_reg;
        held_next    = held_reg;
        present_next = cfg_we ? cfg_wdata : present_reg;
        macc_next    = macc_reg;
        acc_next     = acc_reg;
        defer_next   = defer_reg;
        perr_next    = perr_reg;
        offv_next    = offv_reg;
        offd_next    = offd_reg;
        m_valid_next = (m_valid_reg && m_tready) ? 1'b0 : m_valid_reg;
        m_data_next  = m_data_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;

        port_ok  = (32'(in_port) < NUM_PORTS);
        pidx     = PW'(in_port);
        end_off  = 9'(in_off) + 9'(in_size);
        shifted  = in_data << {in_off[2:0], 3'b000};
        ctrl     = in_data & bytes_mask(in_size);
        enq_req  = 1'b0;
        enq_cmd  = in_data;
        enq_ok   = 1'b0;
        run_head = 1'b0;
        tail_sum = (AW+1)'(head_reg) + (AW+1)'(count_reg);
        ind_idx  = ram_rdata[15:8];
        rel      = '0;
        drained  = (count_reg == '0) && !wif_reg && !ar_reg;
        addr     = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    acc_next   = 1'b0;
                    defer_next = 1'b0;
                    perr_next  = 1'b0;
                    offv_next  = 1'b0;
                    offd_next  = '0;
                    macc_next  = in_macc;
                    case (in_mode)
                        MODE_WINDOW: begin
                            if (in_wr && port_ok && 32'(in_off) < WIN && in_size != '0
                                && 32'(end_off) <= WIN) begin
                                if (32'(in_off) < CMD_BYTES) begin
                                    if (32'(end_off) <= CMD_BYTES) begin
                                        for (int b = 0; b < 8; b++) begin
                                            if (9'(b) >= 9'(in_off) && 9'(b) < end_off) begin
                                                stage_next[pidx][8*b +: 8] = shifted[8*b +: 8];
                                            end
                                        end
                                        acc_next = 1'b1;
                                    end
                                end else if (32'(in_off) == CMD_BYTES
                                             && 32'(in_size) == CMD_BYTES) begin
                                    enq_req = 1'b1;
                                end else if (ctrl == CTRL_PUSH) begin
                                    enq_req = 1'b1;
                                    enq_cmd = stage_reg[pidx];
                                    stage_next[pidx] = '0;
                                end else if (ctrl == CTRL_POP) begin
                                    acc_next = 1'b1;
                                    if (count_reg == '0) begin
                                        perr_next = 1'b1;
                                    end else begin
                                        head_next  = (32'(head_reg) == QUEUE_DEPTH - 1) ?
                                                     '0 : head_reg + 1'b1;
                                        count_next = count_reg - 1'b1;
                                        run_head   = 1'b1;
                                    end
                                end else if (ctrl == CTRL_SYNC_DONE) begin
                                    if (!pend_reg[pidx]) begin
                                        acc_next = 1'b1;
                                        if (!drained) begin
                                            pend_next[pidx] = 1'b1;
                                            defer_next      = 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                        MODE_LAUNCH: begin
                            if (in_wr && port_ok && 32'(in_size) == CMD_BYTES) begin
                                enq_req = 1'b1;
                            end
                        end
                        MODE_INDICATOR: begin
                            if (in_wr && in_size >= 5'd4 && in_data[23:16] == OP_IND_SET
                                && 32'(in_data[15:8]) < NUM_INDICATORS) begin
                                ind_next[IW'(in_data[15:8])] = 1'b1;
                                acc_next = 1'b1;
                                run_head = 1'b1;
                            end
                        end
                        MODE_WR_DONE: begin
                            if (wif_reg) begin
                                acc_next = 1'b1;
                                if (count_reg != '0) begin
                                    head_next  = (32'(head_reg) == QUEUE_DEPTH - 1) ?
                                                 '0 : head_reg + 1'b1;
                                    count_next = count_reg - 1'b1;
                                end else begin
                                    perr_next = 1'b1;
                                end
                                wif_next = 1'b0;
                                ar_next  = 1'b0;
                                run_head = 1'b1;
                            end
                        end
                        MODE_RETRY: begin
                            if (ar_reg && !wif_reg) begin
                                acc_next  = 1'b1;
                                offv_next = 1'b1;
                                offd_next = held_reg;
                                if (in_macc) begin
                                    wif_next = 1'b1;
                                    ar_next  = 1'b0;
                                end
                            end
                        end
                        MODE_TICK: begin
                            acc_next  = 1'b1;
                            gate_next = 1'b1;
                            run_head  = 1'b1;
                        end
                        default: begin
                        end
                    endcase

                    // single enqueue point: tail write into the command RAM
                    if (enq_req) begin
                        enq_ok   = (count_reg < CW'(QUEUE_DEPTH)) && gate_reg;
                        acc_next = enq_ok;
                        if (enq_ok) begin
                            ram_we     = 1'b1;
                            ram_waddr  = (32'(tail_sum) >= QUEUE_DEPTH) ?
                                         AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);
                            ram_wdata  = enq_cmd & CMD_MASK;
                            count_next = count_reg + 1'b1;
                            gate_next  = 1'b0;
                            run_head   = 1'b1;
                        end
                    end
                    state_next = run_head ? ST_HEAD_RD : ST_FINISH;
                end
            end
            ST_HEAD_RD: begin
                // RAM read of the head is issued here whenever the head may move
                if (!present_reg || wif_reg || ar_reg || count_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_HEAD_EV;
                end
            end
            ST_HEAD_EV: begin
                if (ram_rdata[31:28] == DTYPE_SYNC && ram_rdata[23:16] == OP_SYNC_WAIT) begin
                    if (32'(ind_idx) < NUM_INDICATORS && ind_reg[IW'(ind_idx)]) begin
                        ind_next[IW'(ind_idx)] = 1'b0;
                        head_next  = (32'(head_reg) == QUEUE_DEPTH - 1) ?
                                     '0 : head_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                        state_next = ST_HEAD_RD;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end else begin
                    held_next  = ram_rdata;
                    offv_next  = 1'b1;
                    offd_next  = ram_rdata;
                    if (macc_reg) begin
                        wif_next = 1'b1;
                        ar_next  = 1'b0;
                    end else begin
                        ar_next  = 1'b1;
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    if (drained) begin
                        for (int i = 0; i < NUM_PORTS && i < 4; i++) begin
                            rel[i] = pend_reg[i];
                        end
                        pend_next = '0;
                    end
                    if (offv_reg) begin
                        addr = ADDR_BASE | (31'(offd_reg[31:28]) << 24)
                                         | (31'(offd_reg[27:24]) << 20);
                    end
                    m_data_next = '0;
                    m_data_next[0]       = acc_reg;
                    m_data_next[1]       = defer_reg;
                    m_data_next[5:2]     = rel;
                    m_data_next[6]       = offv_reg;
                    m_data_next[37:7]    = addr;
                    m_data_next[101:38]  = offd_reg;
                    m_data_next[102]     = (count_reg < CW'(QUEUE_DEPTH)) && gate_reg;
                    m_data_next[107:103] = 5'(count_reg);
                    m_data_next[108]     = perr_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            for (int p = 0; p < NUM_PORTS; p++) begin
                stage_reg[p] <= '0;
            end
            ind_reg     <= '0;
            pend_reg    <= '0;
            gate_reg    <= 1'b1;
            wif_reg     <= 1'b0;
            ar_reg      <= 1'b0;
            present_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            stage_reg   <= stage_next;
            ind_reg     <= ind_next;
            pend_reg    <= pend_next;
            gate_reg    <= gate_next;
            wif_reg     <= wif_next;
            ar_reg      <= ar_next;
            present_reg <= present_next;
            m_valid_reg <= m_valid_next;
        end
        held_reg   <= held_next;
        macc_reg   <= macc_next;
        acc_reg    <= acc_next;
        defer_reg  <= defer_next;
        perr_reg   <= perr_next;
        offv_reg   <= offv_next;
        offd_reg   <= offd_next;
        m_data_reg <= m_data_next;
    end
endmodule
`default_nettype wire

### hdl/cqsw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cqsw_ram
// Simple dual-port synchronous RAM: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cqsw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                                        aclk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### verif/cqsw_checker.sv
// ----------------------------------------------------------------------------
// cqsw_checker
// Watches both item channels of the command queue, predicts every result
// from accepted input items and compares it field by field.
// ----------------------------------------------------------------------------
module cqsw_checker
    import cqsw_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [2:0]           s_tuser,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_wdata,
    output int                        fail_count,
    output int                        results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPORT = 4;
    localparam int QDEPTH = 16;
    localparam int NIND = 64;

    typedef struct packed {
        logic        perr;
        logic [4:0]  occ;
        logic        can_push;
        logic [63:0] ddata;
        logic [30:0] daddr;
        logic        dvalid;
        logic [3:0]  released;
        logic        deferred;
        logic        accepted;
    } cq_result_t;

    logic [63:0] q_store [QDEPTH];
    logic [3:0]  q_head;
    logic [4:0]  q_count;
    logic [63:0] staging [NPORT];
    logic        ind_bits [NIND];
    logic        sync_pend [NPORT];
    logic        gate_open, wr_busy, retry_wait, ds_present, mem_ok;
    logic [63:0] held_cmd;
    cq_result_t  cur;
    cq_result_t  expected_results [$];

    function automatic logic [63:0] low_bytes(input logic [4:0] n);
        return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    function automatic logic drained();
        return q_count == 0 && !wr_busy && !retry_wait;
    endfunction

    task automatic offer(input logic [63:0] c);
        cur.dvalid = 1'b1;
        cur.ddata  = c;
        cur.daddr  = ADDR_BASE | (31'(c[31:28]) << 24) | (31'(c[27:24]) << 20);
        if (mem_ok) begin
            wr_busy = 1'b1;
            retry_wait = 1'b0;
        end else begin
            retry_wait = 1'b1;
        end
    endtask

    task automatic advance_head();
        logic [63:0] c;
        logic [7:0]  ix;
        forever begin
            if (!ds_present || wr_busy || retry_wait || q_count == 0) return;
            c = q_store[q_head];
            ix = c[15:8];
            if (c[31:28] == DTYPE_SYNC && c[23:16] == OP_SYNC_WAIT) begin
                if (ix >= NIND || !ind_bits[ix]) return;
                ind_bits[ix] = 1'b0;
                q_head++;
                q_count--;
            end else begin
                held_cmd = c;
                offer(c);
                return;
            end
        end
    endtask

    task automatic push_cmd(input logic [63:0] c, output logic ok);
        ok = 1'b0;
        if (q_count >= QDEPTH || !gate_open) return;
        q_store[q_head + q_count[3:0]] = c;
        q_count++;
        gate_open = 1'b0;
        advance_head();
        ok = 1'b1;
    endtask

    task automatic predict_item(input logic [2:0] mode, input logic [S_TDATA_W-1:0] d);
        logic [1:0]  port;
        logic [7:0]  off;
        logic [4:0]  sz;
        logic        wr;
        logic [63:0] val, ctrl;
        logic [31:0] word;
        port = d[1:0];
        off  = d[9:2];
        sz   = d[14:10];
        wr   = d[15];
        val  = d[79:16];
        mem_ok = d[80];
        word = val[31:0];
        cur = '0;
        case (mode)
            MODE_WINDOW: begin
                if (wr && off < 16 && sz != 0 && 9'(off) + 9'(sz) <= 16) begin
                    if (off < 8) begin
                        if (9'(off) + 9'(sz) <= 8) begin
                            for (int i = 0; i < sz; i++)
                                staging[port][8*(off+i) +: 8] = val[8*i +: 8];
                            cur.accepted = 1'b1;
                        end
                    end else if (off == 8 && sz == 8) begin
                        push_cmd(val, cur.accepted);
                    end else begin
                        ctrl = val & low_bytes(sz);
                        if (ctrl == CTRL_PUSH) begin
                            val = staging[port];
                            staging[port] = '0;
                            push_cmd(val, cur.accepted);
                        end else if (ctrl == CTRL_POP) begin
                            cur.accepted = 1'b1;
                            if (q_count == 0) begin
                                cur.perr = 1'b1;
                            end else begin
                                q_head++;
                                q_count--;
                                advance_head();
                            end
                        end else if (ctrl == CTRL_SYNC_DONE && !sync_pend[port]) begin
                            cur.accepted = 1'b1;
                            if (!drained()) begin
                                sync_pend[port] = 1'b1;
                                cur.deferred = 1'b1;
                            end
                        end
                    end
                end
            end
            MODE_LAUNCH: begin
                if (wr && sz == 8) push_cmd(val, cur.accepted);
            end
            MODE_INDICATOR: begin
                if (wr && sz >= 4 && word[23:16] == OP_IND_SET && word[15:8] < NIND) begin
                    ind_bits[word[15:8]] = 1'b1;
                    cur.accepted = 1'b1;
                    advance_head();
                end
            end
            MODE_WR_DONE: begin
                if (wr_busy) begin
                    cur.accepted = 1'b1;
                    if (q_count > 0) begin
                        q_head++;
                        q_count--;
                    end else begin
                        cur.perr = 1'b1;
                    end
                    wr_busy = 1'b0;
                    retry_wait = 1'b0;
                    advance_head();
                end
            end
            MODE_RETRY: begin
                if (retry_wait && !wr_busy) begin
                    cur.accepted = 1'b1;
                    offer(held_cmd);
                end
            end
            MODE_TICK: begin
                cur.accepted = 1'b1;
                gate_open = 1'b1;
                advance_head();
            end
            default: ;
        endcase
        if (drained()) begin
            for (int i = 0; i < NPORT; i++) begin
                if (sync_pend[i]) begin
                    sync_pend[i] = 1'b0;
                    cur.released[i] = 1'b1;
                end
            end
        end
        cur.can_push = (q_count < QDEPTH) && gate_open;
        cur.occ = q_count;
        expected_results.push_back(cur);
    endtask

    always @(posedge aclk) begin
        cq_result_t exp_r, got;
        if (!aresetn) begin
            q_head = '0;
            q_count = '0;
            gate_open = 1'b1;
            wr_busy = 1'b0;
            retry_wait = 1'b0;
            held_cmd = '0;
            ds_present = 1'b1;
            for (int i = 0; i < NPORT; i++) begin
                staging[i] = '0;
                sync_pend[i] = 1'b0;
            end
            for (int i = 0; i < NIND; i++) ind_bits[i] = 1'b0;
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) ds_present = cfg_wdata;
            if (m_tvalid && m_tready) begin
                got = cq_result_t'(m_tdata[108:0]);
                if (expected_results.size() == 0) begin
                    $error("result with no expectation waiting");
                    fail_count++;
                end else begin
                    exp_r = expected_results[0];
                    expected_results.delete(0);
                    if (exp_r.accepted !== got.accepted) begin
                        $error("accepted: expected %0h, actual %0h", exp_r.accepted, got.accepted);
                        fail_count++;
                    end
                    if (exp_r.deferred !== got.deferred) begin
                        $error("deferred: expected %0h, actual %0h", exp_r.deferred, got.deferred);
                        fail_count++;
                    end
                    if (exp_r.released !== got.released) begin
                        $error("released_mask: expected %0h, actual %0h",
                               exp_r.released, got.released);
                        fail_count++;
                    end
                    if (exp_r.dvalid !== got.dvalid) begin
                        $error("dispatch_valid: expected %0h, actual %0h",
                               exp_r.dvalid, got.dvalid);
                        fail_count++;
                    end
                    if (exp_r.daddr !== got.daddr) begin
                        $error("dispatch_addr: expected %0h, actual %0h", exp_r.daddr, got.daddr);
                        fail_count++;
                    end
                    if (exp_r.ddata !== got.ddata) begin
                        $error("dispatch_data: expected %0h, actual %0h", exp_r.ddata, got.ddata);
                        fail_count++;
                    end
                    if (exp_r.can_push !== got.can_push) begin
                        $error("can_push: expected %0h, actual %0h", exp_r.can_push, got.can_push);
                        fail_count++;
                    end
                    if (exp_r.occ !== got.occ) begin
                        $error("occupancy: expected %0h, actual %0h", exp_r.occ, got.occ);
                        fail_count++;
                    end
                    if (exp_r.perr !== got.perr) begin
                        $error("pop_empty_error: expected %0h, actual %0h", exp_r.perr, got.perr);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) predict_item(s_tuser, s_tdata);
        end
        results_owed = expected_results.size();
    end
endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives register-window, launch, indicator, write-done, retry and tick
// items into the command queue with random gaps and output stalls, changes
// downstream_present between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import cqsw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 800000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [2:0]           s_tuser = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 cfg_we = 1'b0;
    logic                 cfg_wdata = 1'b0;
    int                   fail_count, results_owed;
    int                   cycles = 0;
    int                   rx_wait = 0;
    logic                 stim_done = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    command_queue_with_sync_waits dut (.*);

    cqsw_checker checker_i (.*);

    // receiver: random wait per result, with stall-free stretches
    always @(posedge aclk) begin
        int w;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                w = (cycles % 3000 < 600) ? 0 : int'($urandom_range(0, 18));
                rx_wait  <= w;
                m_tready <= (w == 0);
            end else if (rx_wait > 1) begin
                rx_wait <= rx_wait - 1;
            end else begin
                rx_wait  <= 0;
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // one item: gap, then hold valid until the handshake
    task automatic send(input mode_t mode, input logic [1:0] port, input logic [7:0] off,
                        input logic [4:0] sz, input logic wr, input logic [63:0] val,
                        input logic mem_ok);
        int gap;
        gap = (cycles % 4000 < 700) ? 0 : int'($urandom_range(0, 18));
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser  <= mode;
        s_tdata  <= {7'd0, mem_ok, val, wr, sz, off, port};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic set_present(input logic v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [63:0] make_cmd(input logic sync, input logic [7:0] ix);
        logic [63:0] c;
        c = {$urandom, $urandom};
        if (sync) begin
            c[31:28] = DTYPE_SYNC;
            c[23:16] = OP_SYNC_WAIT;
            c[15:8]  = ix;
        end else if (c[31:28] == DTYPE_SYNC) begin
            c[23:16] = 8'h5A;
        end
        return c;
    endfunction

    // random item, weighted toward well-formed queue traffic
    task automatic random_item();
        int k;
        logic [63:0] v;
        logic [7:0]  ix;
        k = $urandom_range(0, 99);
        v = {$urandom, $urandom};
        ix = 8'($urandom_range(0, 63));
        if (k < 14) begin
            send(MODE_LAUNCH, 2'($urandom), 8'd8, 5'd8, 1'b1,
                 make_cmd($urandom_range(0, 2) == 0, ix), 1'($urandom));
        end else if (k < 22) begin
            send(MODE_WINDOW, 2'($urandom), 8'd8, 5'd8, 1'b1,
                 make_cmd($urandom_range(0, 2) == 0, ix), 1'($urandom));
        end else if (k < 30) begin
            send(MODE_WINDOW, 2'($urandom), 8'($urandom_range(0, 7)),
                 5'($urandom_range(1, 8)), 1'b1, v, 1'($urandom));
        end else if (k < 38) begin
            send(MODE_WINDOW, 2'($urandom), 8'($urandom_range(9, 15)), 5'd1, 1'b1,
                 {56'd0, 8'($urandom_range(0, 2))}, 1'($urandom));
        end else if (k < 50) begin
            send(MODE_TICK, 2'($urandom), 8'($urandom), 5'($urandom), 1'($urandom), v,
                 1'($urandom));
        end else if (k < 62) begin
            send(MODE_INDICATOR, 2'($urandom), 8'($urandom), 5'($urandom_range(4, 8)), 1'b1,
                 {v[63:24], OP_IND_SET, ix, v[7:0]}, 1'($urandom));
        end else if (k < 76) begin
            send(MODE_WR_DONE, 2'($urandom), 8'($urandom), 5'($urandom), 1'($urandom), v,
                 1'($urandom));
        end else if (k < 86) begin
            send(MODE_RETRY, 2'($urandom), 8'($urandom), 5'($urandom), 1'($urandom), v,
                 1'($urandom));
        end else begin
            // noise: any field value at all, including modes 6 and 7
            send(mode_t'($urandom_range(0, 7)), 2'($urandom), 8'($urandom),
                 5'($urandom_range(0, 31)), 1'($urandom), v, 1'($urandom));
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, every mode, special cases
        send(MODE_WINDOW, 2'd0, 8'd9, 5'd1, 1'b1, CTRL_POP, 1'b1);          // pop when empty
        send(MODE_WR_DONE, 2'd0, 8'd0, 5'd0, 1'b0, '0, 1'b1);               // done w/o write
        send(MODE_RETRY, 2'd0, 8'd0, 5'd0, 1'b0, '0, 1'b1);                 // retry w/o write
        send(MODE_WINDOW, 2'd3, 8'd0, 5'd8, 1'b0, '1, 1'b1);                // read refused
        send(MODE_WINDOW, 2'd3, 8'd0, 5'd8, 1'b1, 64'h1234_5678_9ABC_DEF0, 1'b1);
        send(MODE_WINDOW, 2'd3, 8'd255, 5'd16, 1'b1, '1, 1'b1);             // out of window
        send(MODE_WINDOW, 2'd3, 8'd7, 5'd2, 1'b1, '1, 1'b1);                // straddles
        send(MODE_WINDOW, 2'd3, 8'd8, 5'd4, 1'b1, 64'hFFFF_FF00_0000_0000, 1'b0); // push
        send(MODE_RETRY, 2'd0, 8'd0, 5'd0, 1'b0, '0, 1'b1);
        send(MODE_WINDOW, 2'd1, 8'd10, 5'd2, 1'b1, CTRL_SYNC_DONE, 1'b1);   // deferred
        send(MODE_WINDOW, 2'd1, 8'd10, 5'd2, 1'b1, CTRL_SYNC_DONE, 1'b1);   // already pending
        send(MODE_WINDOW, 2'd0, 8'd8, 5'd8, 1'b1, 64'hFFFF_FFFF_1000_2A00, 1'b1); // gate shut
        send(MODE_TICK, 2'd0, 8'd0, 5'd0, 1'b0, '0, 1'b0);
        send(MODE_LAUNCH, 2'd2, 8'd0, 5'd8, 1'b1, 64'h0000_0000_1000_2A00, 1'b1); // sync wait
        send(MODE_WR_DONE, 2'd0, 8'd0, 5'd0, 1'b0, '0, 1'b1);               // write done, sync wait blocks
        send(MODE_INDICATOR, 2'd0, 8'd0, 5'd3, 1'b1, 64'h0001_2A00, 1'b1);  // too short
        send(MODE_INDICATOR, 2'd0, 8'd0, 5'd4, 1'b1, 64'h0001_4000, 1'b1);  // index too high
        send(MODE_INDICATOR, 2'd0, 8'd0, 5'd8, 1'b1, 64'h0001_2A00, 1'b1);
        send(MODE_WINDOW, 2'd2, 8'd12, 5'd4, 1'b1, 64'h7, 1'b1);            // bad control
        send(mode_t'(3'd7), 2'd0, 8'd0, 5'd31, 1'b1, '1, 1'b1);
        send(MODE_TICK, 2'd0, 8'd0, 5'd0, 1'b0, '0, 1'b1);

        set_present(1'b0);
        for (int i = 0; i < 400; i++) random_item();
        set_present(1'b1);
        for (int i = 0; i < 600; i++) random_item();
        wait_idle();                     // sender holds until all results are in
        set_present(1'b0);
        for (int i = 0; i < 150; i++) random_item();
        set_present(1'b1);
        for (int i = 0; i < 500; i++) random_item();
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        wait_idle();
        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule

### filelist.f
hdl/cqsw_pkg.sv
hdl/cqsw_ram.sv
hdl/command_queue_with_sync_waits.sv
verif/cqsw_checker.sv
verif/tb_top.sv
